@@ sv/tmh_pkg.sv @@
package tmh_pkg;

  localparam int DL_W   = 48;
  localparam int SOCK_W = 16;
  localparam int TO_W   = 32;
  localparam int OP_W   = 2;

  // most sockets reported by one tick
  localparam int MAX_OUT = 64;
  localparam int OUT_CW  = 7;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  localparam logic [TO_W-1:0] TIMEOUT_RESET = 32'd1000;

  typedef struct packed {
    logic [DL_W-1:0]   deadline;
    logic [SOCK_W-1:0] sock;
    logic              deleted;
  } entry_t;

endpackage

@@ sv/tmh_if.sv @@
interface tmh_in_if
  import tmh_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DL_W-1:0]   now_ms;
  logic [SOCK_W-1:0] sock_id;

  modport source (output valid, operation, now_ms, sock_id, input ready);
  modport sink   (input valid, operation, now_ms, sock_id, output ready);
endinterface

interface tmh_out_if
  import tmh_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SOCK_W-1:0] expired_sock;
  logic              expired_valid;
  logic              status;
  logic              last;

  modport source (output valid, expired_sock, expired_valid, status, last, input ready);
  modport sink   (input valid, expired_sock, expired_valid, status, last, output ready);
endinterface

@@ sv/tmh_heap_mem.sv @@
module tmh_heap_mem
  import tmh_pkg::*;
#(
  parameter int HEAP_DEPTH = 64,
  parameter int AW = $clog2(HEAP_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [HEAP_DEPTH];

  // one write and one registered read per cycle; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/tmh_ctrl.sv @@
module tmh_ctrl
  import tmh_pkg::*;
#(
  parameter int HEAP_DEPTH = 64,
  parameter int AW = $clog2(HEAP_DEPTH),
  parameter int CW = $clog2(HEAP_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [TO_W-1:0] timeout_ms,
  tmh_in_if.sink          req,
  tmh_out_if.source       rsp,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output entry_t          mem_wdata,
  output logic            mem_re,
  output logic [AW-1:0]   mem_raddr,
  input  entry_t          mem_rdata,
  output logic [CW-1:0]   count
);

  localparam int IW = AW + 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SU_RD  = 4'd1;
  localparam logic [3:0] S_SU_CMP = 4'd2;
  localparam logic [3:0] S_SU_WX  = 4'd3;
  localparam logic [3:0] S_FINAL  = 4'd4;
  localparam logic [3:0] S_DL_RD  = 4'd5;
  localparam logic [3:0] S_DL_CHK = 4'd6;
  localparam logic [3:0] S_TK_RD  = 4'd7;
  localparam logic [3:0] S_TK_CHK = 4'd8;
  localparam logic [3:0] S_POP    = 4'd9;
  localparam logic [3:0] S_POP_LD = 4'd10;
  localparam logic [3:0] S_SD_RL  = 4'd11;
  localparam logic [3:0] S_SD_RR  = 4'd12;
  localparam logic [3:0] S_SD_RC  = 4'd13;
  localparam logic [3:0] S_SD_CMP = 4'd14;
  localparam logic [3:0] S_TK_END = 4'd15;

  logic [3:0]        state, state_next;
  logic [DL_W-1:0]   now, now_next;
  logic [SOCK_W-1:0] sock, sock_next;
  entry_t            x, x_next;
  entry_t            lreg, lreg_next;
  entry_t            child, child_next;
  logic [AW-1:0]     pos, pos_next;
  logic [AW-1:0]     cidx, cidx_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     count_next;
  logic [OUT_CW-1:0] n, n_next;
  logic              pend_v, pend_v_next;
  logic [SOCK_W-1:0] pend_sock, pend_sock_next;
  logic              st, st_next;

  logic              o_valid;
  logic [SOCK_W-1:0] o_sock;
  logic              o_xv, o_st, o_last;

  logic              emit;
  logic [SOCK_W-1:0] e_sock;
  logic              e_xv, e_last;

  logic              slot_free;
  logic [AW-1:0]     parent;
  logic [IW-1:0]     left, right, count_ext;
  logic [DL_W:0]     dl_sum;
  logic [DL_W-1:0]   dl_sat;

  assign slot_free = !o_valid || rsp.ready;
  assign parent    = (pos - AW'(1)) >> 1;
  assign left      = {1'b0, pos, 1'b1};
  assign right     = left + IW'(1);
  assign count_ext = IW'(count);
  assign dl_sum    = {1'b0, req.now_ms} + (DL_W + 1)'(timeout_ms);
  assign dl_sat    = dl_sum[DL_W] ? {DL_W{1'b1}} : dl_sum[DL_W-1:0];

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = o_valid;
  assign rsp.expired_sock  = o_sock;
  assign rsp.expired_valid = o_xv;
  assign rsp.status        = o_st;
  assign rsp.last          = o_last;

  // sequence the heap walks over the shared memory port and compare
  always_comb begin
    state_next     = state;
    now_next       = now;
    sock_next      = sock;
    x_next         = x;
    lreg_next      = lreg;
    child_next     = child;
    pos_next       = pos;
    cidx_next      = cidx;
    idx_next       = idx;
    count_next     = count;
    n_next         = n;
    pend_v_next    = pend_v;
    pend_sock_next = pend_sock;
    st_next        = st;
    mem_we         = 1'b0;
    mem_waddr      = pos;
    mem_wdata      = x;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    emit           = 1'b0;
    e_sock         = '0;
    e_xv           = 1'b0;
    e_last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          now_next  = req.now_ms;
          sock_next = req.sock_id;
          st_next   = 1'b0;
          unique case (req.operation)
            OP_ADD: begin
              if (count == CW'(HEAP_DEPTH)) begin
                st_next    = 1'b1;
                state_next = S_FINAL;
              end else begin
                x_next     = '{deadline: dl_sat, sock: req.sock_id, deleted: 1'b0};
                pos_next   = count[AW-1:0];
                count_next = count + CW'(1);
                state_next = (count == '0) ? S_SU_WX : S_SU_RD;
              end
            end
            OP_DEL: begin
              idx_next   = '0;
              state_next = S_DL_RD;
            end
            OP_TICK: begin
              n_next      = '0;
              pend_v_next = 1'b0;
              state_next  = S_TK_RD;
            end
            default: state_next = S_FINAL;
          endcase
        end
      end
      S_SU_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = parent;
        state_next = S_SU_CMP;
      end
      S_SU_CMP: begin
        mem_we = 1'b1;
        if (mem_rdata.deadline > x.deadline) begin
          mem_wdata  = mem_rdata;
          pos_next   = parent;
          state_next = (parent == '0) ? S_SU_WX : S_SU_RD;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_SU_WX: begin
        mem_we     = 1'b1;
        state_next = S_FINAL;
      end
      S_FINAL: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DL_RD: begin
        if (idx >= count) begin
          state_next = S_FINAL;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = idx[AW-1:0];
          state_next = S_DL_CHK;
        end
      end
      S_DL_CHK: begin
        // mark a matching entry, then advance the scan
        if (mem_rdata.sock == sock) begin
          mem_we            = 1'b1;
          mem_waddr         = idx[AW-1:0];
          mem_wdata         = mem_rdata;
          mem_wdata.deleted = 1'b1;
        end
        idx_next   = idx + CW'(1);
        state_next = S_DL_RD;
      end
      S_TK_RD: begin
        if (count == '0 || n == OUT_CW'(MAX_OUT)) begin
          state_next = S_TK_END;
        end else begin
          mem_re     = 1'b1;
          state_next = S_TK_CHK;
        end
      end
      S_TK_CHK: begin
        // hold one expired socket back so the final one can carry last
        if (mem_rdata.deleted) begin
          state_next = S_POP;
        end else if (mem_rdata.deadline > now) begin
          state_next = S_TK_END;
        end else if (!pend_v) begin
          pend_v_next    = 1'b1;
          pend_sock_next = mem_rdata.sock;
          n_next         = n + OUT_CW'(1);
          state_next     = S_POP;
        end else if (slot_free) begin
          emit           = 1'b1;
          e_sock         = pend_sock;
          e_xv           = 1'b1;
          e_last         = 1'b0;
          pend_sock_next = mem_rdata.sock;
          n_next         = n + OUT_CW'(1);
          state_next     = S_POP;
        end
      end
      S_POP: begin
        count_next = count - CW'(1);
        if (count == CW'(1)) begin
          state_next = S_TK_RD;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(count - CW'(1));
          state_next = S_POP_LD;
        end
      end
      S_POP_LD: begin
        x_next     = mem_rdata;
        pos_next   = '0;
        state_next = S_SD_RL;
      end
      S_SD_RL: begin
        if (left >= count_ext) begin
          mem_we     = 1'b1;
          state_next = S_TK_RD;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = left[AW-1:0];
          state_next = S_SD_RR;
        end
      end
      S_SD_RR: begin
        lreg_next = mem_rdata;
        if (right < count_ext) begin
          mem_re     = 1'b1;
          mem_raddr  = right[AW-1:0];
          state_next = S_SD_RC;
        end else begin
          child_next = mem_rdata;
          cidx_next  = left[AW-1:0];
          state_next = S_SD_CMP;
        end
      end
      S_SD_RC: begin
        if (lreg.deadline > mem_rdata.deadline) begin
          child_next = mem_rdata;
          cidx_next  = right[AW-1:0];
        end else begin
          child_next = lreg;
          cidx_next  = left[AW-1:0];
        end
        state_next = S_SD_CMP;
      end
      S_SD_CMP: begin
        mem_we = 1'b1;
        if (x.deadline > child.deadline) begin
          mem_wdata  = child;
          pos_next   = cidx;
          state_next = S_SD_RL;
        end else begin
          state_next = S_TK_RD;
        end
      end
      S_TK_END: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_sock     = pend_v ? pend_sock : '0;
          e_xv       = pend_v;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // advance sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      pend_v <= 1'b0;
      n      <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      pend_v <= pend_v_next;
      n      <= n_next;
    end
    now       <= now_next;
    sock      <= sock_next;
    x         <= x_next;
    lreg      <= lreg_next;
    child     <= child_next;
    pos       <= pos_next;
    cidx      <= cidx_next;
    idx       <= idx_next;
    pend_sock <= pend_sock_next;
    st        <= st_next;
  end

  // hold a result until the receiver takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
    if (emit) begin
      o_sock <= e_sock;
      o_xv   <= e_xv;
      o_st   <= st & ~e_xv;
      o_last <= e_last;
    end
  end

endmodule

@@ sv/timer_min_heap_expiry.sv @@
// Timer queue: a binary min-heap of socket deadlines.
// req carries operation (add, delete, tick, or no operation), now_ms and
// sock_id; a transaction is taken when valid and ready are both high.
// rsp carries the results; every input gives one or more, the final one
// with last set. Add stores now_ms + timeout_ms (saturating) and sets status
// when the heap is full. Delete marks every entry of the socket. Tick drops
// marked entries at the root and reports expired sockets in deadline order,
// at most 64 per tick, one result each.
// cfg_we/cfg_wdata write timeout_ms (1000 after reset); the user must write
// it only while idle, the block itself does not enforce this. Add reads and
// compares each parent on its way up; delete reads and checks every stored
// entry; each pop in a tick walks down, reading the children on each level.
// The heap has a single memory port; one item at a time, ready low meanwhile.
// Reset empties the heap at once (no clearing pass). A stalled receiver
// holds the result register; a tick waits there, an add or delete finishes
// its heap work and waits only to post its result.
module timer_min_heap_expiry
  import tmh_pkg::*;
#(
  parameter int HEAP_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  tmh_in_if.sink          req,
  tmh_out_if.source       rsp,
  input  logic            cfg_we,
  input  logic [TO_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  logic [TO_W-1:0] timeout_ms;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;
  logic [CW-1:0]   count;

  // hold the timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ms <= cfg_wdata;
    end
  end

  tmh_heap_mem #(.HEAP_DEPTH(HEAP_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tmh_ctrl #(.HEAP_DEPTH(HEAP_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .timeout_ms (timeout_ms),
    .req        (req),
    .rsp        (rsp),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .count      (count)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HEAP_DEPTH))
    else $error("entry count exceeds heap depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("ready stayed high after an accepted transaction");

  a_full_is_final: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status |-> rsp.last && !rsp.expired_valid)
    else $error("full status on a non-final or expiry result");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !mem_we)
    else $error("heap written while idle");

endmodule

@@ tb/tmh_tb_if.sv @@
`timescale 1ns / 100ps
// The channel interfaces come from the RTL sources; this file only keeps the
// testbench's shared stimulus and result records.
package tmh_tb_pkg;
  import tmh_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DL_W-1:0]   now_ms;
    logic [SOCK_W-1:0] sock_id;
  } timer_req_t;

  typedef struct packed {
    logic [SOCK_W-1:0] expired_sock;
    logic              expired_valid;
    logic              status;
    logic              last;
  } timer_rsp_t;
endpackage

@@ tb/tb_timer_min_heap_expiry.sv @@
`timescale 1ns / 100ps
module tb_timer_min_heap_expiry;
  import tmh_pkg::*;
  import tmh_tb_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam logic [DL_W-1:0] DL_MAX = '1;
  localparam int CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [TO_W-1:0] cfg_wdata = '0;

  tmh_in_if  req();
  tmh_out_if rsp();

  timer_min_heap_expiry #(.HEAP_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: a shadow heap
  entry_t          shadow_heap[DEPTH];
  int              shadow_count;
  logic [TO_W-1:0] shadow_timeout;

  timer_req_t pending_reqs[$];
  timer_rsp_t expected_rsps[$];
  int errors = 0;
  int n_sent = 0, n_rcvd = 0, n_expired = 0, n_full = 0;
  int cycles = 0;
  bit hold_sender = 0;
  bit long_stall = 0;
  bit in_taken = 0;

  task automatic report(input string what);
    errors++;
    $display("ERROR t=%0t %s", $time, what);
  endtask

  function automatic void swap_entries(int a, int b);
    entry_t t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void sift_down(int pos);
    int child;
    while (2 * pos + 1 < shadow_count) begin
      child = 2 * pos + 1;
      if (child + 1 < shadow_count &&
          shadow_heap[child].deadline > shadow_heap[child + 1].deadline)
        child++;
      if (shadow_heap[pos].deadline > shadow_heap[child].deadline) begin
        swap_entries(pos, child);
        pos = child;
      end else break;
    end
  endfunction

  function automatic void pop_root();
    swap_entries(0, shadow_count - 1);
    shadow_count--;
    sift_down(0);
  endfunction

  function automatic void push_rsp(logic [SOCK_W-1:0] s, logic v, logic st, logic l);
    timer_rsp_t r;
    r.expired_sock = s;
    r.expired_valid = v;
    r.status = st;
    r.last = l;
    expected_rsps.push_back(r);
  endfunction

  // Work out the results of one accepted transaction and update the heap
  function automatic void predict_timer(timer_req_t it);
    logic [DL_W:0] sum;
    int pos, parent, n;
    case (it.operation)
      OP_ADD: begin
        if (shadow_count >= DEPTH) begin
          push_rsp('0, 1'b0, 1'b1, 1'b1);
          n_full++;
        end else begin
          sum = {1'b0, it.now_ms} + (DL_W + 1)'(shadow_timeout);
          pos = shadow_count;
          shadow_heap[pos].deadline = sum[DL_W] ? DL_MAX : sum[DL_W-1:0];
          shadow_heap[pos].sock = it.sock_id;
          shadow_heap[pos].deleted = 1'b0;
          shadow_count++;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (shadow_heap[parent].deadline > shadow_heap[pos].deadline) begin
              swap_entries(parent, pos);
              pos = parent;
            end else break;
          end
          push_rsp('0, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_DEL: begin
        for (int i = 0; i < shadow_count; i++)
          if (shadow_heap[i].sock == it.sock_id) shadow_heap[i].deleted = 1'b1;
        push_rsp('0, 1'b0, 1'b0, 1'b1);
      end
      OP_TICK: begin
        n = 0;
        while (shadow_count > 0 && n < MAX_OUT) begin
          if (shadow_heap[0].deleted) begin
            pop_root();
            continue;
          end
          if (shadow_heap[0].deadline > it.now_ms) break;
          push_rsp(shadow_heap[0].sock, 1'b1, 1'b0, 1'b0);
          n++;
          n_expired++;
          pop_root();
        end
        if (n == 0) push_rsp('0, 1'b0, 1'b0, 1'b1);
        else expected_rsps[$].last = 1'b1;
      end
      default: push_rsp('0, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  // Driver: bursts of offers with random gaps
  int burst_left = 0, gap_left = 0;
  initial begin
    req.valid = 1'b0;
    req.operation = OP_NOP;
    req.now_ms = '0;
    req.sock_id = '0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (gap_left > 0) gap_left--;
      else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      end
      if (req.valid && !in_taken) begin
        // hold the waiting transaction unchanged
      end else if (pending_reqs.size() > 0 && !hold_sender && gap_left == 0) begin
        req.operation <= pending_reqs[0].operation;
        req.now_ms <= pending_reqs[0].now_ms;
        req.sock_id <= pending_reqs[0].sock_id;
        req.valid <= 1'b1;
        if (burst_left > 0) burst_left--;
      end else begin
        req.valid <= 1'b0;
      end
      in_taken = 1'b0;
    end
  end

  // Receiver stall pattern
  int stall_phase = 0;
  initial rsp.ready = 1'b0;
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 23;
    if (rst || long_stall) rsp.ready <= 1'b0;
    else if (stall_phase < 8) rsp.ready <= 1'b1;
    else rsp.ready <= ($urandom_range(0, 3) != 0);
  end

  // Monitor: compare each result against the oldest expectation
  always @(posedge clk) begin
    timer_rsp_t exp_r;
    cycles++;
    if (!rst && rsp.valid && rsp.ready) begin
      n_rcvd++;
      if (expected_rsps.size() == 0) report("result with nothing expected");
      else begin
        exp_r = expected_rsps.pop_front();
        if (rsp.expired_sock !== exp_r.expired_sock)
          report($sformatf("expired_sock %h exp %h", rsp.expired_sock, exp_r.expired_sock));
        if (rsp.expired_valid !== exp_r.expired_valid)
          report($sformatf("expired_valid %b exp %b", rsp.expired_valid, exp_r.expired_valid));
        if (rsp.status !== exp_r.status)
          report($sformatf("status %b exp %b", rsp.status, exp_r.status));
        if (rsp.last !== exp_r.last)
          report($sformatf("last %b exp %b", rsp.last, exp_r.last));
      end
    end
    // record an accepted input transaction at its edge
    if (!rst && req.valid && req.ready) begin
      predict_timer({req.operation, req.now_ms, req.sock_id});
      n_sent++;
      void'(pending_reqs.pop_front());
      in_taken = 1'b1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("timer_min_heap_expiry: mismatch");
      $finish;
    end
  end

  function automatic timer_req_t mk(logic [OP_W-1:0] op, logic [DL_W-1:0] t,
                                    logic [SOCK_W-1:0] s);
    timer_req_t r;
    r.operation = op;
    r.now_ms = t;
    r.sock_id = s;
    return r;
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0 && !req.valid && expected_rsps.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_timeout(logic [TO_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_timeout = v;
  endtask

  // Random phase: mostly adds and ticks around a moving clock
  task automatic random_phase(int count, logic [DL_W-1:0] base, int sock_span);
    logic [DL_W-1:0] clock_ms;
    int sel;
    clock_ms = base;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) clock_ms = DL_W'({$urandom, $urandom});
      else clock_ms += DL_W'($urandom_range(0, 400));
      if (sel < 50)
        pending_reqs.push_back(mk(OP_ADD, clock_ms, SOCK_W'($urandom_range(0, sock_span))));
      else if (sel < 65)
        pending_reqs.push_back(mk(OP_DEL, clock_ms, SOCK_W'($urandom_range(0, sock_span))));
      else if (sel < 95)
        pending_reqs.push_back(mk(OP_TICK, clock_ms, SOCK_W'($urandom_range(0, 65535))));
      else
        pending_reqs.push_back(mk(OP_NOP, DL_W'({$urandom, $urandom}),
                                  SOCK_W'($urandom_range(0, 65535))));
    end
  endtask

  initial begin
    shadow_count = 0;
    shadow_timeout = TIMEOUT_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset timeout, extremes, delete, saturation, empty tick, nop
    pending_reqs.push_back(mk(OP_TICK, '0, '0));
    pending_reqs.push_back(mk(OP_ADD, 48'd0, 16'hFFFF));
    pending_reqs.push_back(mk(OP_ADD, 48'd10, 16'h0000));
    pending_reqs.push_back(mk(OP_ADD, DL_MAX, 16'h5555));
    pending_reqs.push_back(mk(OP_ADD, 48'd5, 16'hAAAA));
    pending_reqs.push_back(mk(OP_DEL, '0, 16'h0000));
    pending_reqs.push_back(mk(OP_DEL, '0, 16'h1234));
    pending_reqs.push_back(mk(OP_TICK, 48'd999, '0));
    pending_reqs.push_back(mk(OP_TICK, 48'd1005, 16'hFFFF));
    pending_reqs.push_back(mk(OP_NOP, DL_MAX, 16'hFFFF));
    pending_reqs.push_back(mk(OP_TICK, DL_MAX - 1, '0));
    pending_reqs.push_back(mk(OP_TICK, DL_MAX, '0));
    drain();

    // Zero timeout, fill past full, then one big tick of 64
    write_timeout('0);
    for (int i = 0; i < 66; i++)
      pending_reqs.push_back(mk(OP_ADD, 48'(i * 7 % 50), 16'(i)));
    pending_reqs.push_back(mk(OP_TICK, 48'd100, '0));
    pending_reqs.push_back(mk(OP_TICK, 48'd100, '0));
    drain();

    // Max timeout with saturation, random traffic under a long receiver stall
    write_timeout('1);
    long_stall = 1;
    random_phase(40, DL_MAX - 48'd5000, 15);
    repeat (1500) @(posedge clk);
    long_stall = 0;
    drain();

    // Sender held back while requests queue up, then mixed timeouts
    hold_sender = 1;
    random_phase(10, 48'd0, 7);
    repeat (50) @(posedge clk);
    hold_sender = 0;
    drain();
    write_timeout(32'd300);
    random_phase(70, 48'd20000, 31);
    drain();
    write_timeout(TO_W'($urandom_range(0, 2000)));
    random_phase(60, 48'd1000000, 63);
    pending_reqs.push_back(mk(OP_TICK, DL_MAX, '0));
    drain();

    $display("sent %0d transactions, received %0d results (%0d expirations, %0d full drops)",
             n_sent, n_rcvd, n_expired, n_full);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("timer_min_heap_expiry: match");
    else
      $display("timer_min_heap_expiry: mismatch");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/tmh_pkg.sv
sv/tmh_if.sv
sv/tmh_heap_mem.sv
sv/tmh_ctrl.sv
sv/timer_min_heap_expiry.sv
tb/tmh_tb_if.sv
tb/tb_timer_min_heap_expiry.sv
